// File: src/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: hue constants, the sector code type and
// the input clamp function. No dependencies.
package hsvrgb_pkg;

    localparam int HueFull = 360;
    localparam int HueSector = 60;
    localparam int ChannelMax = 255;
    localparam int InputOne = 256;
    // 92 full turns: moves every 16-bit signed hue into a non-negative range.
    localparam int HueBias = 33120;
    // floor(2^24 / 360); the quotient estimate is exact or one short.
    localparam int HueRecip = 46603;
    localparam int HueRecipShift = 24;

    typedef enum logic [2:0] {
        SECT_RED     = 3'd0,
        SECT_YELLOW  = 3'd1,
        SECT_GREEN   = 3'd2,
        SECT_CYAN    = 3'd3,
        SECT_BLUE    = 3'd4,
        SECT_MAGENTA = 3'd5
    } t_sector;

    function automatic logic [8:0] clamp_unit(input logic signed [10:0] x);
        logic [8:0] res;
        if (x < 11'sd0) begin
            res = 9'd0;
        end else if (x > 11'(InputOne)) begin
            res = 9'(InputOne);
        end else begin
            res = x[8:0];
        end
        return res;
    endfunction

endpackage

// File: src/hsvrgb_fifo.sv
// Small register-based transaction queue with push/full and pop/empty sides.
// Generic; depends on nothing.
module hsvrgb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wptr, n_wptr;
    logic [PtrW-1:0]  r_rptr, n_rptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CntW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("Queue fill count exceeds its depth.");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("Queue fill count did not grow on a lone push.");
`endif

endmodule

// File: src/hsvrgb_front.sv
// Front part of the HSV to RGB converter: accepts transactions, wraps the hue,
// clamps saturation and value, and finds sector and fraction. Uses hsvrgb_pkg.
module hsvrgb_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic signed [15:0]        i_hue_degrees,
    input  logic signed [10:0]        i_saturation,
    input  logic signed [10:0]        i_brightness,
    output logic                      o_push,
    input  logic                      i_full,
    output hsvrgb_pkg::t_sector       o_sector,
    output logic [FRACTION_BITS-1:0]  o_frac,
    output logic [FRACTION_BITS:0]    o_sat,
    output logic [FRACTION_BITS:0]    o_val
);

    import hsvrgb_pkg::*;

    localparam int Fb = FRACTION_BITS;

    logic                 w_en;
    logic [16:0]          w_hue_biased;
    logic [31:0]          w_hue_prod;
    logic [8:0]           w_sat_c;
    logic [8:0]           w_val_c;
    logic [Fb+8:0]        w_sat_wide;
    logic [Fb+8:0]        w_val_wide;
    logic [16:0]          w_turns;
    logic [16:0]          w_rem;
    logic [8:0]           w_hue;
    t_sector              w_sec;
    logic [8:0]           w_base;
    logic [8:0]           w_offs;
    logic [Fb-1:0]        w_ftab [64];

    logic                 r_v1, r_v2, r_v3;
    logic [16:0]          r_x1;
    logic [7:0]           r_qe1;
    logic [Fb:0]          r_sat1, r_val1, r_sat2, r_val2, r_sat3, r_val3;
    logic [8:0]           r_hue2;
    t_sector              r_sec3;
    logic [Fb-1:0]        r_frac3;

    for (genvar gi = 0; gi < 64; gi++) begin : g_ftab
        localparam int unsigned FracVal =
            (gi < HueSector) ? (gi * (2 ** FRACTION_BITS)) / HueSector : 0;
        assign w_ftab[gi] = FracVal[Fb-1:0];
    end

    assign w_en   = !r_v3 || !i_full;
    assign o_full = !w_en;

    assign w_hue_biased = $unsigned(17'(i_hue_degrees)) + 17'(HueBias);
    assign w_hue_prod   = 32'(w_hue_biased) * 32'(HueRecip);
    assign w_sat_c      = clamp_unit(i_saturation);
    assign w_val_c      = clamp_unit(i_brightness);
    assign w_sat_wide   = {w_sat_c, {Fb{1'b0}}};
    assign w_val_wide   = {w_val_c, {Fb{1'b0}}};

    assign w_turns = 17'(r_qe1) * 17'(HueFull);
    assign w_rem   = r_x1 - w_turns;
    assign w_hue   = (w_rem >= 17'(HueFull)) ? 9'(w_rem - 17'(HueFull)) : w_rem[8:0];

    always_comb begin
        if (r_hue2 >= 9'(5 * HueSector)) begin
            w_sec  = SECT_MAGENTA;
            w_base = 9'(5 * HueSector);
        end else if (r_hue2 >= 9'(4 * HueSector)) begin
            w_sec  = SECT_BLUE;
            w_base = 9'(4 * HueSector);
        end else if (r_hue2 >= 9'(3 * HueSector)) begin
            w_sec  = SECT_CYAN;
            w_base = 9'(3 * HueSector);
        end else if (r_hue2 >= 9'(2 * HueSector)) begin
            w_sec  = SECT_GREEN;
            w_base = 9'(2 * HueSector);
        end else if (r_hue2 >= 9'(HueSector)) begin
            w_sec  = SECT_YELLOW;
            w_base = 9'(HueSector);
        end else begin
            w_sec  = SECT_RED;
            w_base = 9'd0;
        end
    end

    assign w_offs = r_hue2 - w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1    <= w_hue_biased;
            r_qe1   <= w_hue_prod[HueRecipShift+7:HueRecipShift];
            r_sat1  <= w_sat_wide[Fb+8:8];
            r_val1  <= w_val_wide[Fb+8:8];
            r_hue2  <= w_hue;
            r_sat2  <= r_sat1;
            r_val2  <= r_val1;
            r_sec3  <= w_sec;
            r_frac3 <= w_ftab[w_offs[5:0]];
            r_sat3  <= r_sat2;
            r_val3  <= r_val2;
        end
    end

    assign o_push   = r_v3;
    assign o_sector = r_sec3;
    assign o_frac   = r_frac3;
    assign o_sat    = r_sat3;
    assign o_val    = r_val3;

`ifndef ASSERT_OFF
    a_hue_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_hue2 < 9'(HueFull)))
        else $error("Wrapped hue is outside one full turn.");
`endif

endmodule

// File: src/hsvrgb_back.sv
// Back part of the HSV to RGB converter: forms p, q and t, picks the channels by
// sector and scales them to 8 bits. Uses hsvrgb_pkg.
module hsvrgb_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    output logic                      o_pop,
    input  hsvrgb_pkg::t_sector       i_sector,
    input  logic [FRACTION_BITS-1:0]  i_frac,
    input  logic [FRACTION_BITS:0]    i_sat,
    input  logic [FRACTION_BITS:0]    i_val,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue
);

    import hsvrgb_pkg::*;

    localparam int Fb = FRACTION_BITS;
    localparam int Pw = 2 * FRACTION_BITS + 2;
    localparam int Cw = FRACTION_BITS + 9;
    localparam logic [Fb:0] One = {1'b1, {Fb{1'b0}}};

    logic          w_en;
    logic [Pw-1:0] w_sf, w_sg;
    logic [Pw-1:0] w_p, w_q, w_t;
    logic [Fb:0]   w_r, w_g, w_b;
    logic [Cw-1:0] w_rc, w_gc, w_bc;

    logic          r_v1, r_v2, r_v3;
    t_sector       r_sec1, r_sec2;
    logic [Fb:0]   r_val1, r_ns1, r_nq1, r_nt1;
    logic [Fb:0]   r_val2, r_p2, r_q2, r_t2;
    logic [7:0]    r_red, r_green, r_blue;

    assign w_en    = !r_v3 || i_pop;
    assign o_pop   = w_en && !i_empty;
    assign o_empty = !r_v3;

    assign w_sf = Pw'(i_sat) * Pw'(i_frac);
    assign w_sg = Pw'(i_sat) * Pw'(One - (Fb+1)'(i_frac));

    assign w_p = Pw'(r_val1) * Pw'(r_ns1);
    assign w_q = Pw'(r_val1) * Pw'(r_nq1);
    assign w_t = Pw'(r_val1) * Pw'(r_nt1);

    always_comb begin
        unique case (r_sec2)
            SECT_YELLOW: begin
                w_r = r_q2;   w_g = r_val2; w_b = r_p2;
            end
            SECT_GREEN: begin
                w_r = r_p2;   w_g = r_val2; w_b = r_t2;
            end
            SECT_CYAN: begin
                w_r = r_p2;   w_g = r_q2;   w_b = r_val2;
            end
            SECT_BLUE: begin
                w_r = r_t2;   w_g = r_p2;   w_b = r_val2;
            end
            SECT_MAGENTA: begin
                w_r = r_val2; w_g = r_p2;   w_b = r_q2;
            end
            default: begin
                w_r = r_val2; w_g = r_t2;   w_b = r_p2;
            end
        endcase
    end

    assign w_rc = Cw'(w_r) * Cw'(ChannelMax);
    assign w_gc = Cw'(w_g) * Cw'(ChannelMax);
    assign w_bc = Cw'(w_b) * Cw'(ChannelMax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sec1  <= i_sector;
            r_val1  <= i_val;
            r_ns1   <= One - i_sat;
            r_nq1   <= One - w_sf[2*Fb:Fb];
            r_nt1   <= One - w_sg[2*Fb:Fb];
            r_sec2  <= r_sec1;
            r_val2  <= r_val1;
            r_p2    <= w_p[2*Fb:Fb];
            r_q2    <= w_q[2*Fb:Fb];
            r_t2    <= w_t[2*Fb:Fb];
            r_red   <= w_rc[Fb+7:Fb];
            r_green <= w_gc[Fb+7:Fb];
            r_blue  <= w_bc[Fb+7:Fb];
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

`ifndef ASSERT_OFF
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_pop) |=> (r_v3 && $stable(r_red) && $stable(r_green)
                              && $stable(r_blue)))
        else $error("Waiting result changed before it was taken.");
`endif

endmodule

// File: src/hsv_to_rgb_converter_core.sv
// HSV to RGB converter, top level. Instantiates hsvrgb_front, hsvrgb_fifo and
// hsvrgb_back; uses hsvrgb_pkg.
//
// Converts one color per transaction: a signed hue in degrees (wrapped modulo
// 360) and saturation and value with 256 meaning 1.0 (clamped to 0..1.0) give
// 8-bit red, green and blue. One transaction is accepted every clock cycle while
// full is low, and one result can be taken every cycle while empty is low. On
// its way to the output ports a result passes seven register stages: three front
// stages (hue wrap by reciprocal multiply, remainder correction, sector and
// fraction lookup), the first of them loaded at the accepting edge, one in the
// queue, and three back stages set by the multiplier chain (s*f, then v*(1-x),
// then the scale by 255). When results are not popped the back stalls, the
// queue fills, and full rises once the front is also loaded.
module hsv_to_rgb_converter_core #(
    parameter int FRACTION_BITS = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_hue_degrees,
    input  logic signed [10:0] i_saturation,
    input  logic signed [10:0] i_brightness,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    import hsvrgb_pkg::*;

    localparam int Fb = FRACTION_BITS;
    localparam int Qw = 3 + Fb + 2 * (Fb + 1);

    logic          w_fq_push;
    logic          w_fq_full;
    logic          w_qb_pop;
    logic          w_qb_empty;
    t_sector       w_f_sec;
    logic [Fb-1:0] w_f_frac;
    logic [Fb:0]   w_f_sat;
    logic [Fb:0]   w_f_val;
    logic [Qw-1:0] w_q_in;
    logic [Qw-1:0] w_q_out;
    t_sector       w_b_sec;

    hsvrgb_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_hue_degrees (i_hue_degrees),
        .i_saturation  (i_saturation),
        .i_brightness  (i_brightness),
        .o_push        (w_fq_push),
        .i_full        (w_fq_full),
        .o_sector      (w_f_sec),
        .o_frac        (w_f_frac),
        .o_sat         (w_f_sat),
        .o_val         (w_f_val)
    );

    assign w_q_in = {w_f_sec, w_f_frac, w_f_sat, w_f_val};

    hsvrgb_fifo #(
        .WIDTH(Qw),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .o_full  (w_fq_full),
        .i_data  (w_q_in),
        .i_pop   (w_qb_pop),
        .o_empty (w_qb_empty),
        .o_data  (w_q_out)
    );

    assign w_b_sec = t_sector'(w_q_out[Qw-1:Qw-3]);

    hsvrgb_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_qb_empty),
        .o_pop    (w_qb_pop),
        .i_sector (w_b_sec),
        .i_frac   (w_q_out[Qw-4:2*(Fb+1)]),
        .i_sat    (w_q_out[2*Fb+1:Fb+1]),
        .i_val    (w_q_out[Fb:0]),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for hsv_to_rgb_converter_core: random and directed colors are pushed in,
// every popped RGB transaction is checked against a built-in fixed-point predictor.
// Depends on hsvrgb_pkg and the converter RTL only.
module tb_top;

    import hsvrgb_pkg::*;

    localparam int FracBits = 8;
    localparam int FracOne = 1 << FracBits;
    localparam int HoldCycles = 80;
    localparam int StallLimit = 5000;
    localparam int DrainCycles = 20;

    typedef struct packed {
        logic signed [15:0] hue;
        logic signed [10:0] sat;
        logic signed [10:0] val;
    } t_hsv;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic signed [15:0] i_hue_degrees = '0;
    logic signed [10:0] i_saturation = '0;
    logic signed [10:0] i_brightness = '0;
    logic               full;
    logic               empty;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;

    t_hsv pending_colors[$];
    t_rgb expected_rgb[$];
    int   send_idle_pct = 31;
    int   recv_idle_pct = 69;
    int   error_count = 0;
    int   stall_cycles = 0;
    int   hold_left = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    logic color_taken = 1'b0;

    hsv_to_rgb_converter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_hue_degrees(i_hue_degrees),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .empty        (empty),
        .pop          (pop),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #10 i_clk = ~i_clk;

    function automatic int clamp_fraction(logic signed [10:0] raw);
        int x;
        x = int'(raw);
        if (x < 0) begin
            x = 0;
        end else if (x > InputOne) begin
            x = InputOne;
        end
        return x * FracOne / InputOne;
    endfunction

    function automatic logic [7:0] scale_channel(int x);
        int scaled;
        scaled = (x * ChannelMax) >> FracBits;
        return scaled[7:0];
    endfunction

    function automatic t_rgb convert_hsv(t_hsv color);
        int      hue;
        int      s;
        int      v;
        int      frac;
        int      p;
        int      q;
        int      t;
        int      r;
        int      g;
        int      b;
        t_sector sect;
        t_rgb    res;
        hue = int'(color.hue) % HueFull;
        if (hue < 0) begin
            hue += HueFull;
        end
        s = clamp_fraction(color.sat);
        v = clamp_fraction(color.val);
        sect = t_sector'(hue / HueSector);
        frac = (hue % HueSector) * FracOne / HueSector;
        p = (v * (FracOne - s)) >> FracBits;
        q = (v * (FracOne - ((s * frac) >> FracBits))) >> FracBits;
        t = (v * (FracOne - ((s * (FracOne - frac)) >> FracBits))) >> FracBits;
        case (sect)
            SECT_YELLOW: begin
                r = q; g = v; b = p;
            end
            SECT_GREEN: begin
                r = p; g = v; b = t;
            end
            SECT_CYAN: begin
                r = p; g = q; b = v;
            end
            SECT_BLUE: begin
                r = t; g = p; b = v;
            end
            SECT_MAGENTA: begin
                r = v; g = p; b = q;
            end
            default: begin
                r = v; g = t; b = p;
            end
        endcase
        res.red = scale_channel(r);
        res.green = scale_channel(g);
        res.blue = scale_channel(b);
        return res;
    endfunction

    task automatic add_color(int hue, int sat, int val);
        t_hsv color;
        color.hue = 16'(hue);
        color.sat = 11'(sat);
        color.val = 11'(val);
        pending_colors = {pending_colors, color};
    endtask

    // In-range fields mixed with fully random bit patterns: half of the hues, a quarter of saturations and values.
    task automatic add_random_colors(int count);
        t_hsv color;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                color.hue = 16'($urandom);
            end else begin
                color.hue = 16'($urandom_range(0, HueFull - 1));
            end
            if ($urandom_range(0, 3) == 0) begin
                color.sat = 11'($urandom);
            end else begin
                color.sat = 11'($urandom_range(0, InputOne));
            end
            if ($urandom_range(0, 3) == 0) begin
                color.val = 11'($urandom);
            end else begin
                color.val = 11'($urandom_range(0, InputOne));
            end
            pending_colors = {pending_colors, color};
        end
    endtask

    task automatic wait_drained();
        while (pending_colors.size() != 0 || push || expected_rgb.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || color_taken) begin
            if (pending_colors.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_hsv color;
                color = pending_colors.pop_front();
                push <= 1'b1;
                i_hue_degrees <= color.hue;
                i_saturation <= color.sat;
                i_brightness <= color.val;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            color_taken <= push && !full;
            if (push && !full) begin
                t_hsv color;
                color.hue = i_hue_degrees;
                color.sat = i_saturation;
                color.val = i_brightness;
                expected_rgb = {expected_rgb, convert_hsv(color)};
            end
            if (pop && !empty) begin
                if (expected_rgb.size() == 0) begin
                    $error("unexpected result transaction: red %0d green %0d blue %0d",
                           o_red, o_green, o_blue);
                    error_count++;
                end else begin
                    t_rgb want;
                    want = expected_rgb.pop_front();
                    if (o_red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, o_red);
                        error_count++;
                    end
                    if (o_green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, o_green);
                        error_count++;
                    end
                    if (o_blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, o_blue);
                        error_count++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= StallLimit) begin
                $display("tb_top: errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        add_color(0, 256, 256);
        add_color(60, 256, 256);
        add_color(120, 256, 256);
        add_color(180, 256, 256);
        add_color(240, 256, 256);
        add_color(300, 256, 256);
        add_color(359, 256, 256);
        add_color(59, 128, 200);
        add_color(-1, 256, 256);
        add_color(-32768, 1023, 1023);
        add_color(32767, -1024, -1024);
        add_color(360, 257, 255);
        add_color(-360, -1, 256);
        add_color(719, 0, 1023);
        add_color(-719, 1023, 0);
        add_color(90, 255, 257);
        add_color(210, 1, 1);
        add_color(330, 200, -1);
        add_color(-300, 256, 128);
        add_random_colors(270);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        send_idle_pct = 69;
        recv_idle_pct = 31;
        add_random_colors(280);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        add_random_colors(280);

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (expected_rgb.size() != 0) begin
            $error("%0d result transactions never arrived", expected_rgb.size());
        end
        if (error_count == 0 && expected_rgb.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: hsv_to_rgb_converter_core.f
src/hsvrgb_pkg.sv
src/hsvrgb_fifo.sv
src/hsvrgb_front.sv
src/hsvrgb_back.sv
src/hsv_to_rgb_converter_core.sv
test/tb_top.sv
